>>> design/scancode_set1_to_ascii_assert.svh
// ----------------------------------------------------------------------------
// Scancode decoder assertion macros
// Shared property wrappers for the scancode decoder checkers.
// ----------------------------------------------------------------------------
`ifndef SCANCODE_SET1_TO_ASCII_ASSERT_SVH
`define SCANCODE_SET1_TO_ASCII_ASSERT_SVH

// Check a property on every rising edge outside reset.
`define SC2A_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SC2A_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

>>> design/sc2a_pkg.sv
// ----------------------------------------------------------------------------
// Scancode decoder package
// Key codes, character tables and the decode result type.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int unsigned CodeW  = 8;
  localparam int unsigned KeyW   = 7;
  localparam int unsigned CharW  = 7;
  localparam int unsigned DataW  = 8;
  localparam int unsigned RomDepth = 58;
  localparam int unsigned RomAw  = 6;

  localparam logic [KeyW-1:0] KeyLShift    = 7'h2A;
  localparam logic [KeyW-1:0] KeyRShift    = 7'h36;
  localparam logic [KeyW-1:0] KeyCaps      = 7'h3A;
  localparam logic [KeyW-1:0] KeyBackspace = 7'h0E;
  localparam logic [KeyW-1:0] KeyEnter     = 7'h1C;

  localparam logic [CharW-1:0] ChBackspace = 7'h08;
  localparam logic [CharW-1:0] ChEnter     = 7'h0A;
  localparam logic [CharW-1:0] ChLowerA    = 7'h61;
  localparam logic [CharW-1:0] ChLowerZ    = 7'h7A;
  localparam logic [CharW-1:0] ChCaseBit   = 7'h20;

  localparam logic [CharW-1:0] RomPlain [RomDepth] = '{
    7'h00, 7'h1B,
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30,
    7'h2D, 7'h3D, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70,
    7'h5B, 7'h5D, 7'h0A, 7'h00,
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C,
    7'h3B, 7'h27, 7'h60, 7'h00, 7'h5C,
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D,
    7'h2C, 7'h2E, 7'h2F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  localparam logic [CharW-1:0] RomShift [RomDepth] = '{
    7'h00, 7'h1B,
    7'h21, 7'h40, 7'h23, 7'h24, 7'h25, 7'h5E, 7'h26, 7'h2A, 7'h28, 7'h29,
    7'h5F, 7'h2B, 7'h08, 7'h09,
    7'h51, 7'h57, 7'h45, 7'h52, 7'h54, 7'h59, 7'h55, 7'h49, 7'h4F, 7'h50,
    7'h7B, 7'h7D, 7'h0A, 7'h00,
    7'h41, 7'h53, 7'h44, 7'h46, 7'h47, 7'h48, 7'h4A, 7'h4B, 7'h4C,
    7'h3A, 7'h22, 7'h7E, 7'h00, 7'h7C,
    7'h5A, 7'h58, 7'h43, 7'h56, 7'h42, 7'h4E, 7'h4D,
    7'h3C, 7'h3E, 7'h3F, 7'h00, 7'h2A, 7'h00, 7'h20
  };

  typedef struct packed {
    logic             has_char;
    logic [CharW-1:0] character;
  } dec_res_t;

endpackage

>>> design/sc2a_decode.sv
// ----------------------------------------------------------------------------
// Scancode decode
// Shift and caps lock flags plus the character table lookup.
// ----------------------------------------------------------------------------
module sc2a_decode (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sc2a_pkg::CodeW-1:0]    code_i,
  input  logic                          advance_i,
  output sc2a_pkg::dec_res_t            result_o
);
  import sc2a_pkg::*;

  logic            shift_q, shift_d;
  logic            caps_q, caps_d;
  logic [KeyW-1:0] key;
  logic            is_shift_key;
  logic [CharW-1:0] rom_ch;
  logic [CharW-1:0] ch;
  logic [RomAw-1:0] rom_addr;

  assign key          = code_i[KeyW-1:0];
  assign is_shift_key = (key == KeyLShift) || (key == KeyRShift);
  assign rom_addr     = code_i[RomAw-1:0];

  always_comb begin
    if (code_i < CodeW'(RomDepth)) begin
      rom_ch = shift_q ? RomShift[rom_addr] : RomPlain[rom_addr];
    end else begin
      rom_ch = '0;
    end
  end

  always_comb begin
    shift_d = shift_q;
    caps_d  = caps_q;
    ch      = '0;
    if (code_i[CodeW-1]) begin
      if (is_shift_key) begin
        shift_d = 1'b0;
      end
    end else if (is_shift_key) begin
      shift_d = 1'b1;
    end else if (key == KeyCaps) begin
      caps_d = ~caps_q;
    end else if (key == KeyBackspace) begin
      ch = ChBackspace;
    end else if (key == KeyEnter) begin
      ch = ChEnter;
    end else if (caps_q && rom_ch >= ChLowerA && rom_ch <= ChLowerZ) begin
      ch = rom_ch & ~ChCaseBit;
    end else begin
      ch = rom_ch;
    end
  end

  assign result_o.has_char  = (ch != '0);
  assign result_o.character = ch;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      caps_q  <= 1'b0;
    end else if (advance_i) begin
      shift_q <= shift_d;
      caps_q  <= caps_d;
    end
  end

endmodule

>>> design/sc2a_out_stage.sv
// ----------------------------------------------------------------------------
// Scancode output stage
// Result register on the master side, loaded while empty or draining.
// ----------------------------------------------------------------------------
module sc2a_out_stage (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [sc2a_pkg::CharW-1:0]    character_i,
  output logic                          free_o,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [sc2a_pkg::CharW-1:0]    character_o
);
  import sc2a_pkg::*;

  logic             valid_q;
  logic [CharW-1:0] char_q;

  assign free_o      = !valid_q || ready_i;
  assign valid_o     = valid_q;
  assign character_o = char_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && push_i) begin
      char_q <= character_i;
    end
  end

endmodule

>>> design/scancode_set1_to_ascii.sv
// ----------------------------------------------------------------------------
// Set 1 scancode to ASCII decoder
// Turns raw keyboard scancodes into ASCII characters, tracking shift and caps.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one raw set 1 scancode per request; bit 7 marks a release.
//   m_axis carries one ASCII character for each key press that maps to one;
//   releases, modifier keys and unmapped keys give no request.
//   A scancode is taken into the input register, is decoded there against
//   the shift and caps lock flags and lands in the result register, from
//   which its character shows on m_axis. Throughput is one scancode per
//   cycle, set by the single decode stage, while the receiver does not stall.
//   Reset clears both stages and the flags (shift released, caps lock off).
//   When the receiver stalls, the result register holds its character, the
//   input register still takes one more scancode, and s_axis_tready_o drops
//   only once a character waits behind the held one. Scancodes that give no
//   character pass through the decode stage even during a stall.
// ----------------------------------------------------------------------------
module scancode_set1_to_ascii (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] scancode
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o   // [6:0] character, [7] zero
);
  import sc2a_pkg::*;

  logic             in_valid_q;
  logic [CodeW-1:0] code_q;
  logic             advance;
  logic             out_free;
  dec_res_t         result;
  logic [CharW-1:0] out_char;

  assign advance         = in_valid_q && (!result.has_char || out_free);
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      code_q <= s_axis_tdata_i[CodeW-1:0];
    end
  end

  sc2a_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .code_i    (code_q),
    .advance_i (advance),
    .result_o  (result)
  );

  sc2a_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_valid_q && result.has_char),
    .character_i (result.character),
    .free_o      (out_free),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .character_o (out_char)
  );

  assign m_axis_tdata_o = {{(DataW-CharW){1'b0}}, out_char};

endmodule

>>> design/scancode_set1_to_ascii_checker.sv
// ----------------------------------------------------------------------------
// Scancode decoder port checker
// Watches the stream ports of the decoder over time.
// ----------------------------------------------------------------------------
`include "scancode_set1_to_ascii_assert.svh"

module scancode_set1_to_ascii_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o
);

  logic s_fire;
  logic out_ok;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign out_ok = (m_axis_tdata_o[7] == 1'b0) && (m_axis_tdata_o[6:0] != 7'h00);

  `SC2A_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled request changed")
  `SC2A_ASSERT(a_out_char, clk_i, rst_ni, m_axis_tvalid_o |-> out_ok, "character out of range")
  `SC2A_ASSERT(a_stall_cause, clk_i, rst_ni, !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i, "input stalled without output stall")
  `SC2A_ASSERT(a_out_origin, clk_i, rst_ni, $rose(m_axis_tvalid_o) |-> $past(s_fire, 2), "character without scancode")

endmodule

bind scancode_set1_to_ascii scancode_set1_to_ascii_checker u_checker (.*);
